// File: rtl/dfatok_pkg.sv
// Shared types and constants for the DFA tokenizer.
// Used by the channel interfaces, the register block and the scan core.
package dfatok_pkg;

  localparam int ALPHABET  = 128;
  localparam int LOOKAHEAD = 16;

  localparam int ST_W     = 6;
  localparam int SYM_W    = 8;
  localparam int KIND_W   = 6;
  localparam int LEN_W    = 12;
  localparam int POS_W    = 32;
  localparam int INFO_W   = KIND_W + 1;
  localparam int SYM_AW   = $clog2(ALPHABET);
  localparam int TR_AW    = ST_W + SYM_AW;
  localparam int BUF_AW   = $clog2(LOOKAHEAD + 2);
  localparam int BUF_DEPTH = 2 ** BUF_AW;

  localparam logic [SYM_W-1:0] CH_NL  = 8'h0A;
  localparam logic [SYM_W-1:0] CH_TAB = 8'h09;

  localparam logic [1:0] ACT_LOAD_TRANS = 2'd0;
  localparam logic [1:0] ACT_LOAD_INFO  = 2'd1;
  localparam logic [1:0] ACT_CHAR       = 2'd2;
  localparam logic [1:0] ACT_END        = 2'd3;

  localparam logic [1:0] RK_TOKEN = 2'd0;
  localparam logic [1:0] RK_END   = 2'd1;
  localparam logic [1:0] RK_ERROR = 2'd2;

  localparam int APB_AW = 4;
  localparam logic [1:0] REG_INITIAL_STATE = 2'd0;
  localparam logic [1:0] REG_SKIP_KIND     = 2'd1;
  localparam logic [1:0] REG_TAB_WIDTH     = 2'd2;

  localparam logic [ST_W-1:0]   INITIAL_STATE_RST = 6'd1;
  localparam logic [KIND_W-1:0] SKIP_KIND_RST     = 6'd1;
  localparam logic [3:0]        TAB_WIDTH_RST     = 4'd4;

  typedef struct packed {
    logic [1:0]        action;
    logic [ST_W-1:0]   state_index;
    logic [SYM_W-1:0]  symbol;
    logic [ST_W-1:0]   next_state;
    logic              final_flag;
    logic [KIND_W-1:0] token_kind;
  } dfatok_in_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [KIND_W-1:0] kind_of_token;
    logic [POS_W-1:0]  start_line;
    logic [POS_W-1:0]  start_column;
    logic [LEN_W-1:0]  lexeme_length;
    logic [SYM_W-1:0]  error_char;
    logic              last_of_run;
  } dfatok_out_t;

  typedef struct packed {
    logic [ST_W-1:0]   initial_state;
    logic [KIND_W-1:0] skip_kind;
    logic [3:0]        tab_width;
  } dfatok_cfg_t;

endpackage

// File: rtl/dfatok_if.sv
// Valid/ready channel interfaces for input items and result words.
// Depends on dfatok_pkg.
interface dfatok_in_if import dfatok_pkg::*; ();
  logic       valid;
  logic       ready;
  dfatok_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dfatok_out_if import dfatok_pkg::*; ();
  logic        valid;
  logic        ready;
  dfatok_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dfatok_ram.sv
// Generic single-port-write, single-port-read RAM, registered read data.
// No dependencies.
module dfatok_ram #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// File: rtl/dfatok_cfg.sv
// APB register block: initial_state, skip_kind, tab_width.
// Depends on dfatok_pkg.
module dfatok_cfg import dfatok_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output dfatok_cfg_t       cfg
);
  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_state <= INITIAL_STATE_RST;
      cfg.skip_kind     <= SKIP_KIND_RST;
      cfg.tab_width     <= TAB_WIDTH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_INITIAL_STATE: cfg.initial_state <= pwdata[ST_W-1:0];
        REG_SKIP_KIND:     cfg.skip_kind     <= pwdata[KIND_W-1:0];
        REG_TAB_WIDTH:     cfg.tab_width     <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_INITIAL_STATE: prdata = 32'(cfg.initial_state);
      REG_SKIP_KIND:     prdata = 32'(cfg.skip_kind);
      REG_TAB_WIDTH:     prdata = 32'(cfg.tab_width);
      default:           prdata = 32'd0;
    endcase
  end
endmodule

// File: rtl/dfatok_core.sv
// Scan engine: table memories, lookahead ring, position counters, result hold.
// Depends on dfatok_pkg, dfatok_if, dfatok_ram.
module dfatok_core import dfatok_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  dfatok_cfg_t cfg,
  dfatok_in_if.sink   feed,
  dfatok_out_if.source tokens
);
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_FETCH  = 4'd1;
  localparam logic [3:0] S_TRD    = 4'd2;
  localparam logic [3:0] S_INF    = 4'd3;
  localparam logic [3:0] S_COMMIT = 4'd4;
  localparam logic [3:0] S_DEAD   = 4'd5;
  localparam logic [3:0] S_FIN    = 4'd6;
  localparam logic [3:0] S_EOIC   = 4'd7;
  localparam logic [3:0] S_FLUSH  = 4'd8;

  logic [3:0]        state;
  logic [ST_W-1:0]   dfa_state;
  logic [ST_W-1:0]   acc_state;
  logic              acc_valid;
  logic [LEN_W-1:0]  tlen;
  logic [POS_W-1:0]  line, col, tok_line, tok_col;
  logic              halted, eoi;
  logic [BUF_AW-1:0] base, scan, tail;
  logic [SYM_W-1:0]  err_ch;
  logic [SYM_W-1:0]  rbuf [BUF_DEPTH];

  dfatok_out_t hold;
  logic        hold_valid;
  logic        o_valid;
  dfatok_out_t o_data;

  logic              accept, o_free, can_emit, stall;
  logic              emit_req;
  dfatok_out_t       emit_res;
  logic [BUF_AW-1:0] rd_ptr, la_cnt;
  logic [SYM_W-1:0]  rd_ch;
  logic              bad_ch;

  logic              tr_we, tr_re, in_we, in_re;
  logic [TR_AW-1:0]  tr_waddr, tr_raddr;
  logic [ST_W-1:0]   tr_q, in_raddr;
  logic [INFO_W-1:0] in_q;

  logic [POS_W:0]    col_sum;
  logic [POS_W-1:0]  col_step, col_adv, line_adv;

  assign accept       = feed.valid && feed.ready;
  assign feed.ready   = (state == S_IDLE);
  assign tokens.valid = o_valid;
  assign tokens.data  = o_data;
  assign o_free       = !o_valid || tokens.ready;
  assign can_emit     = !hold_valid || o_free;
  assign stall        = emit_req && !can_emit;

  assign rd_ptr = (state == S_COMMIT || state == S_EOIC) ? base : scan;
  assign rd_ch  = rbuf[rd_ptr];
  assign la_cnt = scan - base;
  assign bad_ch = 9'(rd_ch) >= 9'(ALPHABET);

  // table memories
  assign tr_we    = accept && feed.data.action == ACT_LOAD_TRANS &&
                    9'(feed.data.symbol) < 9'(ALPHABET);
  assign tr_waddr = {feed.data.state_index, feed.data.symbol[SYM_AW-1:0]};
  assign tr_re    = (state == S_FETCH) && (scan != tail) && !bad_ch;
  assign tr_raddr = {dfa_state, rd_ch[SYM_AW-1:0]};
  assign in_we    = accept && feed.data.action == ACT_LOAD_INFO;
  assign in_re    = (state == S_TRD) ||
                    ((state == S_DEAD || state == S_EOIC) && acc_valid);
  assign in_raddr = (state == S_TRD) ? tr_q : acc_state;

  dfatok_ram #(.DW(ST_W), .AW(TR_AW)) u_trans (
    .clk(clk), .we(tr_we), .waddr(tr_waddr), .wdata(feed.data.next_state),
    .re(tr_re), .raddr(tr_raddr), .rdata(tr_q)
  );

  dfatok_ram #(.DW(INFO_W), .AW(ST_W)) u_info (
    .clk(clk), .we(in_we), .waddr(feed.data.state_index),
    .wdata({feed.data.final_flag, feed.data.token_kind}),
    .re(in_re), .raddr(in_raddr), .rdata(in_q)
  );

  // position advance for the committed character
  assign col_step = (rd_ch == CH_TAB) ? 32'(cfg.tab_width) : 32'd1;
  assign col_sum  = {1'b0, col} + {1'b0, col_step};
  assign col_adv  = col_sum[POS_W] ? '1 : col_sum[POS_W-1:0];
  assign line_adv = (line == '1) ? line : line + 32'd1;

  always_comb begin
    emit_req               = 1'b0;
    emit_res.result_kind   = RK_ERROR;
    emit_res.kind_of_token = '0;
    emit_res.start_line    = tok_line;
    emit_res.start_column  = tok_col;
    emit_res.lexeme_length = '0;
    emit_res.error_char    = '0;
    emit_res.last_of_run   = 1'b0;
    unique case (state)
      S_INF: begin
        if (!in_q[INFO_W-1] && la_cnt >= BUF_AW'(LOOKAHEAD)) begin
          emit_req            = 1'b1;
          emit_res.error_char = rd_ch;
        end
      end
      S_DEAD: begin
        if (!acc_valid) begin
          emit_req            = 1'b1;
          emit_res.error_char = rd_ch;
        end
      end
      S_FIN: begin
        if (in_q[KIND_W-1:0] == '0) begin
          emit_req            = 1'b1;
          emit_res.error_char = err_ch;
        end else if (in_q[KIND_W-1:0] != cfg.skip_kind) begin
          emit_req               = 1'b1;
          emit_res.result_kind   = RK_TOKEN;
          emit_res.kind_of_token = in_q[KIND_W-1:0];
          emit_res.lexeme_length = tlen;
        end
      end
      S_EOIC: begin
        if (!acc_valid) begin
          emit_req = 1'b1;
          if (scan != base) begin
            emit_res.error_char = rd_ch;
          end else begin
            emit_res.result_kind = RK_END;
          end
        end
      end
      default: ;
    endcase
  end

  // result hold and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      hold_valid <= 1'b0;
    end else if (emit_req && can_emit) begin
      if (hold_valid) begin
        o_data  <= hold;
        o_valid <= 1'b1;
      end else if (tokens.ready) begin
        o_valid <= 1'b0;
      end
      hold       <= emit_res;
      hold_valid <= 1'b1;
    end else if (state == S_FLUSH && hold_valid && o_free) begin
      o_data             <= hold;
      o_data.last_of_run <= 1'b1;
      o_valid            <= 1'b1;
      hold_valid         <= 1'b0;
    end else if (tokens.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && feed.data.action == ACT_CHAR && !halted) begin
      rbuf[tail] <= feed.data.symbol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dfa_state <= INITIAL_STATE_RST;
      acc_state <= '0;
      acc_valid <= 1'b0;
      tlen      <= '0;
      line      <= 32'd1;
      col       <= 32'd1;
      tok_line  <= 32'd1;
      tok_col   <= 32'd1;
      halted    <= 1'b0;
      eoi       <= 1'b0;
      base      <= '0;
      scan      <= '0;
      tail      <= '0;
      err_ch    <= '0;
    end else if (!stall) begin
      unique case (state)
        S_IDLE: begin
          if (accept && !halted) begin
            if (feed.data.action == ACT_CHAR) begin
              tail  <= tail + 1'b1;
              state <= S_FETCH;
            end else if (feed.data.action == ACT_END) begin
              eoi   <= 1'b1;
              state <= S_EOIC;
            end
          end
        end
        S_FETCH: begin
          if (scan == tail) begin
            state <= eoi ? S_EOIC : S_FLUSH;
          end else if (bad_ch) begin
            state <= S_DEAD;
          end else begin
            state <= S_TRD;
          end
        end
        S_TRD: begin
          state <= (tr_q == '0) ? S_DEAD : S_INF;
        end
        S_INF: begin
          dfa_state <= tr_q;
          if (in_q[INFO_W-1]) begin
            acc_valid <= 1'b1;
            acc_state <= tr_q;
            state     <= S_COMMIT;
          end else if (emit_req) begin
            halted <= 1'b1;
            eoi    <= 1'b0;
            state  <= S_FLUSH;
          end else begin
            scan  <= scan + 1'b1;
            state <= S_FETCH;
          end
        end
        S_COMMIT: begin
          if (rd_ch == CH_NL) begin
            line <= line_adv;
            col  <= 32'd1;
          end else begin
            col <= col_adv;
          end
          if (tlen != '1) begin
            tlen <= tlen + 1'b1;
          end
          base <= base + 1'b1;
          if (base == scan) begin
            scan  <= scan + 1'b1;
            state <= S_FETCH;
          end
        end
        S_DEAD: begin
          if (!acc_valid) begin
            halted <= 1'b1;
            eoi    <= 1'b0;
            state  <= S_FLUSH;
          end else begin
            err_ch <= rd_ch;
            state  <= S_FIN;
          end
        end
        S_FIN: begin
          if (in_q[KIND_W-1:0] == '0) begin
            halted <= 1'b1;
            eoi    <= 1'b0;
            state  <= S_FLUSH;
          end else begin
            tok_line  <= line;
            tok_col   <= col;
            dfa_state <= cfg.initial_state;
            acc_valid <= 1'b0;
            acc_state <= '0;
            tlen      <= '0;
            scan      <= base;
            state     <= S_FETCH;
          end
        end
        S_EOIC: begin
          if (acc_valid) begin
            err_ch <= (scan != base) ? rd_ch : '0;
            state  <= S_FIN;
          end else if (scan != base) begin
            halted <= 1'b1;
            eoi    <= 1'b0;
            state  <= S_FLUSH;
          end else begin
            tok_line  <= line;
            tok_col   <= col;
            dfa_state <= cfg.initial_state;
            tlen      <= '0;
            eoi       <= 1'b0;
            state     <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!hold_valid || o_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/table_driven_dfa_tokenizer.sv
// Top level of the maximal-munch DFA tokenizer: register block and scan core.
// Depends on dfatok_pkg, dfatok_if, dfatok_cfg, dfatok_core.
//
//   port    dir   handshake          word
//   feed    in    valid/ready        dfatok_in_t  (load, character, end)
//   tokens  out   valid/ready        dfatok_out_t (token, end, error)
//   apb     in    psel/penable       32-bit register write/read
//
// Loads are written from the idle state. Each DFA step reads the transition RAM,
// then the state-info RAM, then updates; each accept adds a commit step per committed
// character, each dead transition a dead and a finish step before the lookahead is rescanned.
// An item ends with a flush step that releases its last result word.
// Synchronous reset, no clearing pass; the tables are undefined until loaded.
// A full output register with a result already in the hold stalls the core at its next result.
module table_driven_dfa_tokenizer import dfatok_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  dfatok_in_if.sink         feed,
  dfatok_out_if.source      tokens,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  dfatok_cfg_t cfg;

  dfatok_cfg u_cfg (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  dfatok_core u_core (
    .clk(clk), .rst(rst), .cfg(cfg), .feed(feed), .tokens(tokens)
  );
endmodule

// File: tb/sv/table_driven_dfa_tokenizer_tb.sv
// Self-checking testbench for the maximal-munch DFA tokenizer.
// Loads full tables, scans directed and random text, checks every result word.
// Depends on dfatok_pkg, dfatok_if and table_driven_dfa_tokenizer.
`timescale 1ns / 1ps

module table_driven_dfa_tokenizer_tb;
  import dfatok_pkg::*;

  localparam int NSTATES = 64;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dfatok_in_if  feed ();
  dfatok_out_if tokens ();

  table_driven_dfa_tokenizer u_dut (
    .clk(clk), .rst(rst), .feed(feed), .tokens(tokens),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // scanner shadow
  logic [5:0] trans_tbl [NSTATES*ALPHABET];
  logic [6:0] info_tbl [NSTATES];
  logic [7:0] look_buf [LOOKAHEAD];
  int cur_st, acc_st, look_cnt, tok_len;
  logic [31:0] line_no, col_no, tok_line, tok_col;
  bit halted;
  int init_st = 1, skip_k = 1, tab_w = 4;

  dfatok_out_t word_q[$];
  dfatok_out_t run_words[$];
  dfatok_in_t pend_q[$];
  int fails = 0;
  int send_idle = 0, recv_idle = 0;
  bit stall_req = 0, stall_seen = 0;
  int stall_cnt = 0;
  int cycles = 0;

  function automatic void put_word(logic [1:0] rk, int kind, int len, int ech);
    dfatok_out_t w;
    if (run_words.size() >= 17) return;
    w.result_kind = rk;
    w.kind_of_token = kind[5:0];
    w.start_line = tok_line;
    w.start_column = tok_col;
    w.lexeme_length = len[11:0];
    w.error_char = ech[7:0];
    w.last_of_run = 1'b0;
    run_words.push_back(w);
  endfunction

  function automatic void lex_error(int ch);
    put_word(RK_ERROR, 0, 0, ch);
    halted = 1;
  endfunction

  function automatic void step_pos(logic [7:0] ch);
    logic [31:0] st;
    if (ch == CH_NL) begin
      if (line_no != 32'hFFFF_FFFF) line_no++;
      col_no = 1;
    end else begin
      st = (ch == CH_TAB) ? tab_w : 1;
      col_no = (col_no > 32'hFFFF_FFFF - st) ? 32'hFFFF_FFFF : col_no + st;
    end
    if (tok_len < 4095) tok_len++;
  endfunction

  function automatic void new_lexeme();
    tok_line = line_no;
    tok_col = col_no;
    cur_st = init_st;
    acc_st = 0;
    tok_len = 0;
    look_cnt = 0;
  endfunction

  function automatic bit close_lexeme();
    int kind;
    kind = (acc_st < NSTATES) ? info_tbl[acc_st][5:0] : 0;
    if (acc_st == 0 || kind == 0) return 0;
    if (kind != skip_k) put_word(RK_TOKEN, kind, tok_len, 0);
    new_lexeme();
    return 1;
  endfunction

  function automatic void scan(logic [7:0] q[$]);
    logic [7:0] c;
    logic [7:0] nq[$];
    int nxt;
    while (q.size() > 0 && !halted) begin
      c = q.pop_front();
      nxt = (cur_st >= NSTATES || c >= ALPHABET) ? 0 : trans_tbl[cur_st*ALPHABET + c];
      if (nxt != 0) begin
        cur_st = nxt;
        if (info_tbl[nxt][6]) begin
          acc_st = nxt;
          for (int i = 0; i < look_cnt; i++) step_pos(look_buf[i]);
          step_pos(c);
          look_cnt = 0;
        end else if (look_cnt >= LOOKAHEAD) begin
          lex_error(c);
        end else begin
          look_buf[look_cnt++] = c;
        end
      end else begin
        nq.delete();
        for (int i = 0; i < look_cnt; i++) nq.push_back(look_buf[i]);
        if (!close_lexeme()) begin
          lex_error(c);
          return;
        end
        nq.push_back(c);
        while (q.size() > 0) nq.push_back(q.pop_front());
        q = nq;
      end
    end
  endfunction

  function automatic void predict(dfatok_in_t it);
    logic [7:0] q[$];
    int cnt;
    run_words.delete();
    case (it.action)
      ACT_LOAD_TRANS: begin
        if (it.symbol < ALPHABET)
          trans_tbl[it.state_index*ALPHABET + it.symbol] = it.next_state;
      end
      ACT_LOAD_INFO: info_tbl[it.state_index] = {it.final_flag, it.token_kind};
      ACT_CHAR: begin
        if (!halted) begin
          q.push_back(it.symbol);
          scan(q);
        end
      end
      default: begin
        while (!halted) begin
          if (acc_st != 0) begin
            q.delete();
            cnt = look_cnt;
            for (int i = 0; i < cnt; i++) q.push_back(look_buf[i]);
            if (!close_lexeme()) begin
              lex_error(cnt ? look_buf[0] : 0);
              break;
            end
            scan(q);
          end else if (look_cnt != 0) begin
            lex_error(look_buf[0]);
          end else begin
            put_word(RK_END, 0, 0, 0);
            new_lexeme();
            break;
          end
        end
      end
    endcase
    if (run_words.size() > 0) run_words[run_words.size()-1].last_of_run = 1'b1;
    foreach (run_words[i]) word_q.push_back(run_words[i]);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      feed.valid <= 1'b0;
    end else begin
      if (feed.valid && feed.ready) predict(feed.data);
      if (!feed.valid || feed.ready) begin
        if (pend_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          feed.data <= pend_q.pop_front();
          feed.valid <= 1'b1;
        end else begin
          feed.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      stall_cnt <= 400;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    dfatok_out_t e, a;
    if (rst) begin
      tokens.ready <= 1'b0;
    end else begin
      if (tokens.valid && tokens.ready) begin
        a = tokens.data;
        if (word_q.size() == 0) begin
          $error("unexpected word: kind %0d", a.result_kind);
          fails++;
        end else begin
          e = word_q.pop_front();
          if (a.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind); fails++;
          end
          if (a.kind_of_token !== e.kind_of_token) begin
            $error("kind_of_token exp %0d got %0d", e.kind_of_token, a.kind_of_token); fails++;
          end
          if (a.start_line !== e.start_line) begin
            $error("start_line exp %0d got %0d", e.start_line, a.start_line); fails++;
          end
          if (a.start_column !== e.start_column) begin
            $error("start_column exp %0d got %0d", e.start_column, a.start_column); fails++;
          end
          if (a.lexeme_length !== e.lexeme_length) begin
            $error("lexeme_length exp %0d got %0d", e.lexeme_length, a.lexeme_length); fails++;
          end
          if (a.error_char !== e.error_char) begin
            $error("error_char exp %0d got %0d", e.error_char, a.error_char); fails++;
          end
          if (a.last_of_run !== e.last_of_run) begin
            $error("last_of_run exp %0d got %0d", e.last_of_run, a.last_of_run); fails++;
          end
        end
      end
      tokens.ready <= (stall_cnt == 0) && ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic dfatok_in_t mk(logic [1:0] act, int si, int sym, int ns, int ff, int kd);
    dfatok_in_t it;
    it.action = act;
    it.state_index = si[5:0];
    it.symbol = sym[7:0];
    it.next_state = ns[5:0];
    it.final_flag = ff[0];
    it.token_kind = kd[5:0];
    return it;
  endfunction

  function automatic void push_ch(int c);
    pend_q.push_back(mk(ACT_CHAR, $urandom_range(63), c, $urandom_range(63),
                        $urandom_range(1), $urandom_range(63)));
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_ch(s[i]);
  endfunction

  function automatic int col_of(int s, int c);
    bit letter, digit, ws;
    letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    digit = c >= "0" && c <= "9";
    ws = c == " " || c == CH_TAB || c == CH_NL;
    case (s)
      1, 15, 63: begin
        if (letter) return (s == 15) ? 3 : 2;
        if (digit) return 3;
        if (ws) return 4;
        if (c == "<") return 7;
        if (c == "\"") return 11;
        if (c == "@") return 13;
        return 14;
      end
      2: return (letter || digit) ? 2 : 0;
      3: return digit ? 3 : 0;
      4: return ws ? 4 : 0;
      7: return (c == "!") ? 8 : 0;
      8: return (c == "-") ? 9 : 0;
      9: return (c == "-") ? 10 : 0;
      11: return (c == "\"") ? 12 : 11;
      default: return 0;
    endcase
  endfunction

  function automatic int plain_char();
    int c;
    do c = $urandom_range(127);
    while (col_of(1, c) != 14 || c == "@");
    return c;
  endfunction

  function automatic void push_lexeme();
    int n;
    case ($urandom_range(9))
      0, 1: begin
        push_ch("a" + $urandom_range(25));
        n = $urandom_range(5);
        repeat (n) push_ch($urandom_range(1) ? "0" + $urandom_range(9) : "A" + $urandom_range(25));
      end
      2: repeat ($urandom_range(1, 4)) push_ch("0" + $urandom_range(9));
      3: repeat ($urandom_range(1, 3)) push_ch($urandom_range(2) == 0 ? CH_NL :
                                               $urandom_range(1) ? CH_TAB : " ");
      4: begin
        push_ch("\"");
        n = $urandom_range(14);
        repeat (n) begin
          int c;
          do c = $urandom_range(127); while (c == "\"");
          push_ch(c);
        end
        push_ch("\"");
      end
      5: push_text("<!--");
      6: push_text($urandom_range(1) ? "<!-" : "<!");
      7: push_ch("<");
      8: pend_q.push_back(mk(ACT_LOAD_INFO, 14, $urandom_range(255), $urandom_range(63), 1,
                             $urandom_range(2, 63)));
      default: push_ch(plain_char());
    endcase
    if ($urandom_range(11) == 0) pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
  endfunction

  task automatic wait_idle();
    while (pend_q.size() > 0 || feed.valid || word_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    wait_idle();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INITIAL_STATE: init_st = val & 63;
      REG_SKIP_KIND: skip_k = val & 63;
      default: tab_w = val & 15;
    endcase
  endtask

  initial begin
    int ns;
    feed.valid = 1'b0;
    feed.data = '0;
    tokens.ready = 1'b0;
    line_no = 1; col_no = 1; halted = 0;
    new_lexeme();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int s = 0; s < NSTATES; s++) begin
      for (int c = 0; c < ALPHABET; c++) begin
        ns = (s >= 16 && s < 63) ? $urandom_range(63) : col_of(s, c);
        pend_q.push_back(mk(ACT_LOAD_TRANS, s, c, ns, $urandom_range(1), $urandom_range(63)));
      end
      case (s)
        2: ns = 64 + 5;
        3: ns = 64 + 6;
        4: ns = 64 + 1;
        7: ns = 64 + 7;
        10: ns = 64 + 8;
        12: ns = 64 + 9;
        13: ns = 64;
        14: ns = 64 + 10;
        default: ns = (s >= 16 && s < 63) ? $urandom_range(127) : 0;
      endcase
      pend_q.push_back(mk(ACT_LOAD_INFO, s, $urandom_range(255), $urandom_range(63),
                          ns >> 6, ns & 63));
      if (s == 62) wait_idle();
    end
    // loads outside the alphabet are ignored
    pend_q.push_back(mk(ACT_LOAD_TRANS, 1, 255, 63, 1, 63));
    pend_q.push_back(mk(ACT_LOAD_TRANS, 2, 128, 0, 0, 0));

    // directed text: tokens, skips, tabs, newlines, partial lookahead, end
    push_text("ab9 12\t\n<!--x\"q\"<!-");
    pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
    pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
    write_reg(REG_TAB_WIDTH, 1);
    write_reg(REG_SKIP_KIND, 5);
    write_reg(REG_INITIAL_STATE, 15);
    push_text("\tab <x");
    pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
    write_reg(REG_TAB_WIDTH, 8);
    write_reg(REG_SKIP_KIND, 63);
    write_reg(REG_INITIAL_STATE, 63);
    push_text(" z\t7");
    pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
    write_reg(REG_SKIP_KIND, 0);
    write_reg(REG_INITIAL_STATE, 1);
    write_reg(REG_SKIP_KIND, 1);
    write_reg(REG_TAB_WIDTH, 4);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 23 : (ph == 1) ? 86 : 0;
      recv_idle = (ph == 0) ? 86 : (ph == 1) ? 23 : 0;
      repeat (60) push_lexeme();
      if (ph == 2) stall_req = ~stall_req;
      repeat (60) push_lexeme();
      wait_idle();
      if (ph == 0) write_reg(REG_TAB_WIDTH, $urandom_range(1, 8));
      if (ph == 1) write_reg(REG_INITIAL_STATE, 15);
    end
    write_reg(REG_INITIAL_STATE, 1);

    // unclosed string overflows the lookahead; the scanner then stays halted
    push_ch("\"");
    repeat (17) push_ch("a");
    push_text("b1");
    pend_q.push_back(mk(ACT_END, 0, 0, 0, 0, 0));
    wait_idle();

    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
